FILE: rtl/sla_pkg.sv
// Shared types, constants and lookup functions for the status LED animator.
package sla_pkg;

  // Field and datapath widths.
  localparam int unsigned TimeW      = 32;
  localparam int unsigned PeriodW    = 12;
  localparam int unsigned PhaseBits  = 9;
  localparam int unsigned PatternCnt = 6;

  // The elapsed time is reduced modulo the period one byte at a time, high byte first.
  // Each byte step forms x = rem * 256 + byte (below 2^20) and takes its quotient as
  // (x * ceil(2^32 / period)) >> 32, exact for every period in the pattern table.
  localparam int unsigned ByteSteps  = TimeW / 8;
  localparam int unsigned StepW      = $clog2(ByteSteps);
  localparam int unsigned DivInW     = PeriodW + 8;
  localparam int unsigned RecipW     = 23;
  localparam int unsigned RecipShift = 32;
  localparam int unsigned QuoW       = 11;
  localparam int unsigned QuoProdW   = DivInW + RecipW;
  localparam int unsigned QuoBackW   = QuoW + PeriodW;

  // The phase (rem * 512) / period is taken as (rem * ceil(2^33 / period)) >> 24.
  localparam int unsigned PhRecipW   = 24;
  localparam int unsigned PhShift    = 24;
  localparam int unsigned PhProdW    = PeriodW + PhRecipW;

  // Brightness curve and register reset values.
  localparam logic [7:0] LevelFloor = 8'd40;
  localparam logic [7:0] LevelSpan  = 8'd215;
  localparam logic [7:0] LevelFull  = 8'd255;
  localparam logic [7:0] LevelOff   = 8'd0;
  localparam logic [7:0] MaxBrightReset = 8'd64;

  // Input word kinds.
  localparam logic MODE_SET   = 1'b0;
  localparam logic MODE_FRAME = 1'b1;

  // Pattern codes.
  localparam logic [2:0] PAT_IDLE    = 3'd0;
  localparam logic [2:0] PAT_DIALING = 3'd1;
  localparam logic [2:0] PAT_CALLING = 3'd2;
  localparam logic [2:0] PAT_RINGING = 3'd3;
  localparam logic [2:0] PAT_IN_CALL = 3'd4;
  localparam logic [2:0] PAT_ERROR   = 3'd5;

  typedef enum logic [1:0] {
    STYLE_STEADY,
    STYLE_BREATH,
    STYLE_PULSE,
    STYLE_BLINK
  } style_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_PH,
    ST_SQ,
    ST_LVL,
    ST_SCL,
    ST_COL
  } state_e;

  typedef struct packed {
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    style_e              style;
    logic [PeriodW-1:0]  period;
    logic [RecipW-1:0]   recip;
    logic [PhRecipW-1:0] ph_recip;
  } look_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic set_pat;   // store a new pattern if it differs
    logic load;      // capture elapsed time and clear the remainder
    logic mul;       // quotient estimate of one byte step
    logic sub;       // remainder update of one byte step
    logic ph;        // phase from the final remainder
    logic sq;        // gamma stage
    logic lvl;       // brightness level stage
    logic scl;       // max brightness scaling stage
    logic col;       // color scaling into the output register
  } cmd_t;

  // Color, animation style, period and period reciprocals of one pattern.
  function automatic look_t look_of(input logic [2:0] pat);
    look_t lk;
    case (pat)
      PAT_IDLE:    lk = '{8'd0,   8'd0,   8'd255, STYLE_BREATH, 12'd4000,
                          23'd1073742, 24'd2147484};
      PAT_DIALING: lk = '{8'd255, 8'd255, 8'd255, STYLE_STEADY, 12'd0,
                          23'd0, 24'd0};
      PAT_CALLING: lk = '{8'd255, 8'd170, 8'd0,   STYLE_PULSE,  12'd900,
                          23'd4772186, 24'd9544372};
      PAT_RINGING: lk = '{8'd255, 8'd0,   8'd0,   STYLE_BLINK,  12'd600,
                          23'd7158279, 24'd14316558};
      PAT_IN_CALL: lk = '{8'd0,   8'd255, 8'd0,   STYLE_BREATH, 12'd4000,
                          23'd1073742, 24'd2147484};
      PAT_ERROR:   lk = '{8'd255, 8'd0,   8'd0,   STYLE_STEADY, 12'd0,
                          23'd0, 24'd0};
      default:     lk = '{8'd0,   8'd0,   8'd255, STYLE_BREATH, 12'd4000,
                          23'd1073742, 24'd2147484};
    endcase
    return lk;
  endfunction

  // Exact floor(x / 255) for x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

FILE: rtl/sla_ctrl.sv
// Sequencer for the status LED animator: accepts words and steps the datapath.
module sla_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          mode_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sla_pkg::cmd_t cmd_o
);

  sla_pkg::state_e            state_q, state_d;
  logic [sla_pkg::StepW-1:0]  step_q, step_d;
  logic                       out_valid_q, out_valid_d;
  logic                       in_fire;
  logic                       slot_free;

  assign in_ready_o  = (state_q == sla_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // State, step counter and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sla_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      sla_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (mode_i == sla_pkg::MODE_FRAME) begin
            cmd_o.load = 1'b1;
            step_d     = '0;
            state_d    = sla_pkg::ST_MUL;
          end else begin
            cmd_o.set_pat = 1'b1;
          end
        end
      end
      sla_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = sla_pkg::ST_SUB;
      end
      sla_pkg::ST_SUB: begin
        // Each byte of the elapsed time takes a multiply step and then a subtract step.
        cmd_o.sub = 1'b1;
        if (step_q == sla_pkg::StepW'(sla_pkg::ByteSteps - 1)) begin
          state_d = sla_pkg::ST_PH;
        end else begin
          step_d  = step_q + sla_pkg::StepW'(1);
          state_d = sla_pkg::ST_MUL;
        end
      end
      sla_pkg::ST_PH: begin
        cmd_o.ph = 1'b1;
        state_d  = sla_pkg::ST_SQ;
      end
      sla_pkg::ST_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = sla_pkg::ST_LVL;
      end
      sla_pkg::ST_LVL: begin
        cmd_o.lvl = 1'b1;
        state_d   = sla_pkg::ST_SCL;
      end
      sla_pkg::ST_SCL: begin
        cmd_o.scl = 1'b1;
        state_d   = sla_pkg::ST_COL;
      end
      sla_pkg::ST_COL: begin
        // Wait here until the output register can take the word.
        if (slot_free) begin
          cmd_o.col   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = sla_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sla_pkg::ST_IDLE;
      end
    endcase
  end

  // The output register is only overwritten once its word is gone.
  a_col_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.col |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while still pending");

  // A finished frame leaves a pending result and returns to idle.
  a_col_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.col |=> (out_valid_q && state_q == sla_pkg::ST_IDLE))
    else $error("frame completion did not post a result");

  // A frame word starts the modulo from the first byte.
  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == sla_pkg::ST_MUL && step_q == '0))
    else $error("frame word did not start the modulo");

  // Every quotient estimate is followed by its remainder update.
  a_mul_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul |=> (state_q == sla_pkg::ST_SUB))
    else $error("quotient estimate not followed by remainder update");

endmodule

FILE: rtl/sla_datapath.sv
// Datapath of the status LED animator: pattern state, divider and color scaling.
module sla_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sla_pkg::cmd_t             cmd_i,
  input  logic                      cfg_valid_i,
  input  logic [7:0]                cfg_data_i,
  input  logic [2:0]                pattern_i,
  input  logic [sla_pkg::TimeW-1:0] now_ms_i,
  output logic [7:0]                green_o,
  output logic [7:0]                red_o,
  output logic [7:0]                blue_o
);

  logic [2:0]                       pattern_q;
  logic [sla_pkg::TimeW-1:0]        start_q;
  logic [7:0]                       max_bright_q;
  logic [sla_pkg::TimeW-1:0]        elapsed_q;
  logic [sla_pkg::PeriodW-1:0]      rem_q, rem_d;
  logic [sla_pkg::QuoW-1:0]         quo_q, quo_d;
  logic [sla_pkg::PhaseBits-1:0]    phase_q, phase_d;
  logic [7:0]                       gamma_q;
  logic [7:0]                       level_q, level_d;
  logic [7:0]                       scale_q;
  logic [7:0]                       green_q, red_q, blue_q;
  sla_pkg::look_t                   look;
  logic [sla_pkg::DivInW-1:0]       div_in;
  logic [sla_pkg::QuoProdW-1:0]     quo_prod;
  logic [sla_pkg::QuoBackW-1:0]     quo_back;
  logic [sla_pkg::PhProdW-1:0]      phase_prod;
  logic [7:0]                       tri_val;

  assign look = sla_pkg::look_of(pattern_q);

  // Pattern, start time and max brightness register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q    <= sla_pkg::PAT_IDLE;
      start_q      <= '0;
      max_bright_q <= sla_pkg::MaxBrightReset;
    end else begin
      if (cfg_valid_i) begin
        max_bright_q <= cfg_data_i;
      end
      if (cmd_i.set_pat && (pattern_i < 3'(sla_pkg::PatternCnt))
          && (pattern_i != pattern_q)) begin
        pattern_q <= pattern_i;
        start_q   <= now_ms_i;
      end
    end
  end

  // One byte step of the modulo: reciprocal quotient, then remainder.
  assign div_in   = {rem_q, elapsed_q[sla_pkg::TimeW-1 -: 8]};
  assign quo_prod = sla_pkg::QuoProdW'(div_in) * sla_pkg::QuoProdW'(look.recip);
  assign quo_d    = quo_prod[sla_pkg::RecipShift +: sla_pkg::QuoW];
  assign quo_back = sla_pkg::QuoBackW'(quo_q) * sla_pkg::QuoBackW'(look.period);
  assign rem_d    = sla_pkg::PeriodW'(sla_pkg::QuoBackW'(div_in) - quo_back);

  // Phase of the final remainder within the period, 0 to 511.
  assign phase_prod = sla_pkg::PhProdW'(rem_q) * sla_pkg::PhProdW'(look.ph_recip);
  assign phase_d    = phase_prod[sla_pkg::PhShift +: sla_pkg::PhaseBits];

  // Triangle wave from the phase.
  assign tri_val = phase_q[sla_pkg::PhaseBits-1] ? ~phase_q[7:0] : phase_q[7:0];

  // Brightness level by animation style.
  always_comb begin
    case (look.style) inside
      sla_pkg::STYLE_BREATH, sla_pkg::STYLE_PULSE: begin
        level_d = sla_pkg::LevelFloor
                + sla_pkg::div255(16'(gamma_q) * 16'(sla_pkg::LevelSpan));
      end
      sla_pkg::STYLE_BLINK: begin
        level_d = (rem_q < (look.period >> 1)) ? sla_pkg::LevelFull : sla_pkg::LevelOff;
      end
      default: begin
        level_d = sla_pkg::LevelFull;
      end
    endcase
  end

  // Modulo, curve and scaling stages.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      elapsed_q <= now_ms_i - start_q;
      rem_q     <= '0;
    end else if (cmd_i.sub) begin
      elapsed_q <= elapsed_q << 8;
      rem_q     <= rem_d;
    end
    if (cmd_i.mul) begin
      quo_q <= quo_d;
    end
    if (cmd_i.ph) begin
      phase_q <= phase_d;
    end
    if (cmd_i.sq) begin
      gamma_q <= sla_pkg::div255(16'(tri_val) * 16'(tri_val));
    end
    if (cmd_i.lvl) begin
      level_q <= level_d;
    end
    if (cmd_i.scl) begin
      scale_q <= sla_pkg::div255(16'(level_q) * 16'(max_bright_q));
    end
    if (cmd_i.col) begin
      green_q <= sla_pkg::div255(16'(look.green) * 16'(scale_q));
      red_q   <= sla_pkg::div255(16'(look.red) * 16'(scale_q));
      blue_q  <= sla_pkg::div255(16'(look.blue) * 16'(scale_q));
    end
  end

  assign green_o = green_q;
  assign red_o   = red_q;
  assign blue_o  = blue_q;

endmodule

FILE: rtl/status_led_animator.sv
// A set word is handled in its accepting cycle; no word is accepted while a frame is in progress.
// A frame word runs through the accepting cycle, four byte steps (multiply, then subtract) of
// the reciprocal modulo, one phase stage and four curve and scaling stages.
// A pixel still waiting in the output register holds the next frame in its last stage.
// Reset (asynchronous, active low) selects the idle pattern, start time 0, max brightness 64.
// Top level of the status LED animator: sequencer plus datapath.
module status_led_animator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [2:0]  pattern_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  green_o,
  output logic [7:0]  red_o,
  output logic [7:0]  blue_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  sla_pkg::cmd_t cmd;
  logic          cfg_fire;

  // The register write is always taken at once.
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Sequencer.
  sla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Datapath.
  sla_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_valid_i (cfg_fire),
    .cfg_data_i  (cfg_data_i),
    .pattern_i   (pattern_i),
    .now_ms_i    (now_ms_i),
    .green_o     (green_o),
    .red_o       (red_o),
    .blue_o      (blue_o)
  );

endmodule
